>>> rtl/prh_pkg.sv
// Shared types, codes, widths and helper functions of the projection histogram.
`timescale 1ns / 1ps

package prh_pkg;

    // Field widths
    localparam int CMD_W     = 2;
    localparam int PIX_W     = 8;
    localparam int IDX_W     = 10;
    localparam int CNT_W     = 11;
    localparam int SUM_W     = 21;
    localparam int KIND_W    = 2;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 3;

    // Stream packing
    localparam int IN_DATA_W  = 24;
    localparam int IN_PAD_W   = IN_DATA_W - PIX_W - IDX_W;
    localparam int OUT_DATA_W = 80;
    localparam int OUT_PAD_W  = OUT_DATA_W - IDX_W - 3 * SUM_W;

    // Result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = 4;
    // Room kept free for one item in the stage register and one being accepted
    localparam int FIFO_ROOM  = FIFO_DEPTH - 4;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_WIDTH  = 11'd640;
    localparam logic [CFG_W-1:0] RST_HEIGHT = 11'd480;
    localparam logic [CFG_W-1:0] RST_SPLIT  = 11'd0;
    localparam logic [PIX_W-1:0] RST_MASK   = 8'hf8;

    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_PIXEL = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        KIND_ROW   = 2'd0,
        KIND_FRAME = 2'd1,
        KIND_COL   = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH     = 3'd0,
        CFG_HEIGHT    = 3'd1,
        CFG_SPLIT_COL = 3'd2,
        CFG_SPLIT_ROW = 3'd3,
        CFG_MASK      = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
        logic [CFG_W-1:0] split_col;
        logic [CFG_W-1:0] split_row;
        logic [PIX_W-1:0] mask;
    } t_cfg;

    // Stage register contents: which results an item raised, and their data
    typedef struct packed {
        logic             row;
        logic             frame;
        logic             rd;
        logic [IDX_W-1:0] row_idx;
        logic [CNT_W-1:0] row_cnt;
        logic [SUM_W-1:0] total;
        logic [SUM_W-1:0] ul;
        logic [SUM_W-1:0] ur;
        logic [IDX_W-1:0] rd_col;
    } t_s1;

    typedef struct packed {
        t_kind            kind;
        logic [IDX_W-1:0] index;
        logic [SUM_W-1:0] count;
        logic [SUM_W-1:0] ul;
        logic [SUM_W-1:0] ur;
        logic             last;
    } t_result;

    function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

endpackage

>>> rtl/prh_col_store.sv
// Per-column count memory with read-modify-write, bypass and clearing pass.
`timescale 1ns / 1ps

module prh_col_store #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic                            i_start,
    input  logic                            i_req_wr,
    input  logic [$clog2(MAX_WIDTH)-1:0]    i_req_addr,
    input  logic                            i_req_zero,
    output logic                            o_busy,
    output logic [prh_pkg::CNT_W-1:0]       o_count
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic [prh_pkg::CNT_W-1:0] r_mem [MAX_WIDTH];
    logic [prh_pkg::CNT_W-1:0] r_rd_data;
    logic                      r_op_wr;
    logic [AW-1:0]             r_op_addr;
    logic                      r_op_zero;
    logic                      r_byp_vld;
    logic [AW-1:0]             r_byp_addr;
    logic [prh_pkg::CNT_W-1:0] r_byp_data;
    logic                      r_clr;
    logic [AW-1:0]             r_clr_addr;

    logic [prh_pkg::CNT_W-1:0] cur;
    logic [prh_pkg::CNT_W-1:0] wr_data;

    // Value of the entry in stage: last cycle's write wins over the RAM output
    always_comb begin
        cur     = (r_byp_vld && (r_byp_addr == r_op_addr)) ? r_byp_data : r_rd_data;
        wr_data = prh_pkg::sat_cnt(cur);
        o_count = r_op_zero ? '0 : cur;
        o_busy  = r_clr;
    end

    // Memory write port: clearing sweep or count update
    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            r_mem[r_clr_addr] <= '0;
        end else if (r_op_wr) begin
            r_mem[r_op_addr] <= wr_data;
        end
    end

    // Memory read port, registered
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_rd_data <= r_mem[i_req_addr];
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_op_addr <= i_req_addr;
            r_op_zero <= i_req_zero;
        end
        r_byp_addr <= r_op_addr;
        r_byp_data <= wr_data;
    end

    // Stage control and clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_wr    <= 1'b0;
            r_byp_vld  <= 1'b0;
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_op_wr   <= i_accept && i_req_wr;
            r_byp_vld <= r_op_wr && !i_start;
            if (r_clr) begin
                if (r_clr_addr == AW'(MAX_WIDTH - 1)) begin
                    r_clr      <= 1'b0;
                    r_clr_addr <= '0;
                end else begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
            end else if (i_start) begin
                r_clr      <= 1'b1;
                r_clr_addr <= '0;
            end
        end
    end

endmodule

>>> rtl/prh_frame_ctrl.sv
// Raster position tracking, row and quadrant counters, and the result stage register.
`timescale 1ns / 1ps

module prh_frame_ctrl #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  prh_pkg::t_cfg                   i_cfg,
    input  logic                            i_accept,
    input  logic [prh_pkg::CMD_W-1:0]       i_cmd,
    input  logic [prh_pkg::PIX_W-1:0]       i_pix,
    input  logic [prh_pkg::IDX_W-1:0]       i_col,
    output logic                            o_start,
    output logic                            o_req_wr,
    output logic [$clog2(MAX_WIDTH)-1:0]    o_req_addr,
    output logic                            o_req_zero,
    output prh_pkg::t_s1                    o_s1
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WW  = ($clog2(MAX_WIDTH + 1) > prh_pkg::CFG_W) ?
                         $clog2(MAX_WIDTH + 1) : prh_pkg::CFG_W;
    localparam int HW  = ($clog2(MAX_HEIGHT + 1) > prh_pkg::CFG_W) ?
                         $clog2(MAX_HEIGHT + 1) : prh_pkg::CFG_W;
    // Wide enough for the read index and for MAX_WIDTH itself
    localparam int XW  = ($clog2(MAX_WIDTH + 1) > prh_pkg::IDX_W) ?
                         $clog2(MAX_WIDTH + 1) : prh_pkg::IDX_W;

    logic [AW-1:0]             r_col_pos, n_col_pos;
    logic [prh_pkg::CNT_W-1:0] r_row_pos, n_row_pos;
    logic [prh_pkg::CNT_W-1:0] r_row_cnt, n_row_cnt;
    logic [prh_pkg::SUM_W-1:0] r_left, n_left;
    logic [prh_pkg::SUM_W-1:0] r_right, n_right;
    logic [prh_pkg::SUM_W-1:0] r_total, n_total;
    prh_pkg::t_s1              r_s1, n_s1;

    logic [WW-1:0]             cfg_w;
    logic [WW-1:0]             w_eff;
    logic [HW-1:0]             cfg_h;
    logic [HW-1:0]             h_eff;
    logic                      active;
    logic                      pix_set;
    logic                      row_end;
    logic                      upper;
    logic                      left;
    logic [prh_pkg::CNT_W-1:0] row_inc;
    logic [XW-1:0]             col_x;

    // Effective frame size and per-pixel conditions
    always_comb begin
        cfg_w   = WW'(i_cfg.width);
        w_eff   = (cfg_w == '0) ? WW'(1) :
                  (cfg_w > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : cfg_w;
        cfg_h   = HW'(i_cfg.height);
        h_eff   = (cfg_h == '0) ? HW'(1) :
                  (cfg_h > HW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : cfg_h;
        active  = HW'(r_row_pos) < h_eff;
        pix_set = (i_pix & i_cfg.mask) != '0;
        row_end = (WW'(r_col_pos) + WW'(1)) >= w_eff;
        upper   = r_row_pos < i_cfg.split_row;
        left    = WW'(r_col_pos) < WW'(i_cfg.split_col);
        row_inc = prh_pkg::sat_cnt(r_row_pos);
        col_x   = XW'(i_col);
    end

    // Next state, memory request and stage contents
    always_comb begin
        n_col_pos  = r_col_pos;
        n_row_pos  = r_row_pos;
        n_row_cnt  = r_row_cnt;
        n_left     = r_left;
        n_right    = r_right;
        n_total    = r_total;
        n_s1       = '0;
        o_start    = 1'b0;
        o_req_wr   = 1'b0;
        o_req_addr = r_col_pos;
        o_req_zero = 1'b0;
        if (i_accept) begin
            case (i_cmd)
                prh_pkg::CMD_START: begin
                    o_start   = 1'b1;
                    n_col_pos = '0;
                    n_row_pos = '0;
                    n_row_cnt = '0;
                    n_left    = '0;
                    n_right   = '0;
                    n_total   = '0;
                end
                prh_pkg::CMD_PIXEL: begin
                    if (active) begin
                        o_req_wr = pix_set;
                        if (pix_set) begin
                            n_row_cnt = prh_pkg::sat_cnt(r_row_cnt);
                            n_total   = prh_pkg::sat_sum(r_total);
                            if (upper) begin
                                if (left) begin
                                    n_left = prh_pkg::sat_sum(r_left);
                                end else begin
                                    n_right = prh_pkg::sat_sum(r_right);
                                end
                            end
                        end
                        if (row_end) begin
                            n_s1.row     = 1'b1;
                            n_s1.row_idx = r_row_pos[prh_pkg::IDX_W-1:0];
                            n_s1.row_cnt = n_row_cnt;
                            n_col_pos    = '0;
                            n_row_cnt    = '0;
                            n_row_pos    = row_inc;
                            if (HW'(row_inc) >= h_eff) begin
                                n_s1.frame = 1'b1;
                                n_s1.total = n_total;
                                n_s1.ul    = n_left;
                                n_s1.ur    = n_right;
                            end
                        end else begin
                            n_col_pos = r_col_pos + 1'b1;
                        end
                    end
                end
                prh_pkg::CMD_READ: begin
                    n_s1.rd     = 1'b1;
                    n_s1.rd_col = i_col;
                    o_req_addr  = AW'(col_x);
                    o_req_zero  = !(col_x < XW'(MAX_WIDTH));
                end
                default: begin
                end
            endcase
        end
    end

    // State and stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos <= '0;
            r_row_pos <= '0;
            r_row_cnt <= '0;
            r_left    <= '0;
            r_right   <= '0;
            r_total   <= '0;
            r_s1      <= '0;
        end else begin
            r_col_pos <= n_col_pos;
            r_row_pos <= n_row_pos;
            r_row_cnt <= n_row_cnt;
            r_left    <= n_left;
            r_right   <= n_right;
            r_total   <= n_total;
            r_s1      <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

>>> rtl/prh_result_fifo.sv
// Result queue that takes up to two results per cycle and hands out one on each pop.
`timescale 1ns / 1ps

module prh_result_fifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push0,
    input  logic                        i_push1,
    input  prh_pkg::t_result            i_data0,
    input  prh_pkg::t_result            i_data1,
    input  logic                        i_pop,
    output prh_pkg::t_result            o_data,
    output logic                        o_valid,
    output logic [prh_pkg::FIFO_CW-1:0] o_count
);

    prh_pkg::t_result                r_buf [prh_pkg::FIFO_DEPTH];
    logic [prh_pkg::FIFO_AW-1:0]     r_wp;
    logic [prh_pkg::FIFO_AW-1:0]     r_rp;
    logic [prh_pkg::FIFO_CW-1:0]     r_cnt;

    logic                            pop_ok;
    logic [prh_pkg::FIFO_AW-1:0]     wp1;

    always_comb begin
        pop_ok  = i_pop && (r_cnt != '0);
        wp1     = r_wp + 1'b1;
        o_valid = r_cnt != '0;
        o_data  = r_buf[r_rp];
        o_count = r_cnt;
    end

    // Entry storage; the second result of an item lands behind the first
    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_buf[r_wp] <= i_data0;
        end
        if (i_push1) begin
            r_buf[wp1] <= i_data1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + prh_pkg::FIFO_AW'(i_push0) + prh_pkg::FIFO_AW'(i_push1);
            r_rp  <= r_rp + prh_pkg::FIFO_AW'(pop_ok);
            r_cnt <= r_cnt + prh_pkg::FIFO_CW'(i_push0) + prh_pkg::FIFO_CW'(i_push1)
                     - prh_pkg::FIFO_CW'(pop_ok);
        end
    end

endmodule

>>> rtl/pixel_projection_histogram_core.sv
// Top level of the row/column projection histogram: config registers, stream ports, wiring.
`timescale 1ns / 1ps

// Takes one item per clock while the slave tready is high: a start command, a
// pixel, or a column read (command in tuser). Pixel and read work is one pass
// from the input to a stage register; the column memory is read at accept and
// updated the next cycle, with a one-entry bypass so back-to-back hits on a
// column are exact. Results pass through an 8-entry queue and leave one per
// clock while the master tready is high; a pixel that ends the last row raises
// two results (row count, then frame totals). After reset and after every start
// command the column memory is swept to zero, one entry a cycle, over MAX_WIDTH
// entries (1024 by default); tready is low during that sweep and whenever the
// queue has fewer than four free entries. Config writes are taken at any time.
module pixel_projection_histogram_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Config write port
    input  logic                                i_cfg_we,
    input  logic [prh_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [prh_pkg::CFG_W-1:0]           i_cfg_data,
    // Input stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata: pixel_value[7:0], column_index[17:8], zero pad[23:18]
    input  logic [prh_pkg::IN_DATA_W-1:0]       i_s_axis_tdata,
    // tuser: command[1:0]
    input  logic [prh_pkg::CMD_W-1:0]           i_s_axis_tuser,
    // Result stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // tdata: index[9:0], count[30:10], upper_left[51:31], upper_right[72:52], pad[79:73]
    output logic [prh_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    // tuser: kind[1:0]
    output logic [prh_pkg::KIND_W-1:0]          o_m_axis_tuser,
    output logic                                o_m_axis_tlast
);

    localparam int AW = $clog2(MAX_WIDTH);

    prh_pkg::t_cfg                r_cfg;
    prh_pkg::t_s1                 s1;
    prh_pkg::t_result             res0;
    prh_pkg::t_result             res1;
    prh_pkg::t_result             head;
    logic                         accept;
    logic                         start;
    logic                         req_wr;
    logic [AW-1:0]                req_addr;
    logic                         req_zero;
    logic                         busy;
    logic [prh_pkg::CNT_W-1:0]    col_count;
    logic                         push0;
    logic                         push1;
    logic [prh_pkg::FIFO_CW-1:0]  fifo_cnt;
    logic                         fifo_vld;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width     <= prh_pkg::RST_WIDTH;
            r_cfg.height    <= prh_pkg::RST_HEIGHT;
            r_cfg.split_col <= prh_pkg::RST_SPLIT;
            r_cfg.split_row <= prh_pkg::RST_SPLIT;
            r_cfg.mask      <= prh_pkg::RST_MASK;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                prh_pkg::CFG_WIDTH:     r_cfg.width     <= i_cfg_data;
                prh_pkg::CFG_HEIGHT:    r_cfg.height    <= i_cfg_data;
                prh_pkg::CFG_SPLIT_COL: r_cfg.split_col <= i_cfg_data;
                prh_pkg::CFG_SPLIT_ROW: r_cfg.split_row <= i_cfg_data;
                prh_pkg::CFG_MASK:      r_cfg.mask      <= i_cfg_data[prh_pkg::PIX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input handshake: keep queue room for the stage and the new item
    assign o_s_axis_tready = !busy && (fifo_cnt <= prh_pkg::FIFO_CW'(prh_pkg::FIFO_ROOM));
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    prh_frame_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_frame_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_accept   (accept),
        .i_cmd      (i_s_axis_tuser),
        .i_pix      (i_s_axis_tdata[prh_pkg::PIX_W-1:0]),
        .i_col      (i_s_axis_tdata[prh_pkg::PIX_W+prh_pkg::IDX_W-1:prh_pkg::PIX_W]),
        .o_start    (start),
        .o_req_wr   (req_wr),
        .o_req_addr (req_addr),
        .o_req_zero (req_zero),
        .o_s1       (s1)
    );

    prh_col_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_col_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_start    (start),
        .i_req_wr   (req_wr),
        .i_req_addr (req_addr),
        .i_req_zero (req_zero),
        .o_busy     (busy),
        .o_count    (col_count)
    );

    // Build the results of the item in stage, in delivery order
    always_comb begin
        res0.kind  = prh_pkg::KIND_ROW;
        res0.index = s1.row_idx;
        res0.count = prh_pkg::SUM_W'(s1.row_cnt);
        res0.ul    = '0;
        res0.ur    = '0;
        res0.last  = !s1.frame;
        if (s1.rd) begin
            res0.kind  = prh_pkg::KIND_COL;
            res0.index = s1.rd_col;
            res0.count = prh_pkg::SUM_W'(col_count);
            res0.last  = 1'b1;
        end
        res1.kind  = prh_pkg::KIND_FRAME;
        res1.index = '0;
        res1.count = s1.total;
        res1.ul    = s1.ul;
        res1.ur    = s1.ur;
        res1.last  = 1'b1;
        push0      = s1.row || s1.rd;
        push1      = s1.frame;
    end

    prh_result_fifo u_result_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (push0),
        .i_push1 (push1),
        .i_data0 (res0),
        .i_data1 (res1),
        .i_pop   (i_m_axis_tready),
        .o_data  (head),
        .o_valid (fifo_vld),
        .o_count (fifo_cnt)
    );

    // Result stream packing
    assign o_m_axis_tvalid = fifo_vld;
    assign o_m_axis_tdata  = {{prh_pkg::OUT_PAD_W{1'b0}}, head.ur, head.ul, head.count,
                              head.index};
    assign o_m_axis_tuser  = head.kind;
    assign o_m_axis_tlast  = head.last;

endmodule
